FILE: rtl/core/sgl_pkg.sv
// ----------------------------------------------------------------------------
// sgl_pkg: shared types and constants for the signed 128-bit gcd/lcm unit
// Beat structs for both channels, the classified job passed front to back,
// and the back-end sequencer states.
// ----------------------------------------------------------------------------
package sgl_pkg;

	localparam int unsigned WordW = 128;
	localparam int unsigned HalfW = 64;
	localparam int unsigned CntW  = 7;
	localparam int unsigned QueueDepthDef = 2;

	localparam logic MODE_GCD = 1'b0;
	localparam logic MODE_LCM = 1'b1;

	typedef struct packed {
		logic                    mode;
		logic signed [HalfW-1:0] a_hi;
		logic [HalfW-1:0]        a_lo;
		logic signed [HalfW-1:0] b_hi;
		logic [HalfW-1:0]        b_lo;
	} in_beat_t;

	typedef struct packed {
		logic signed [HalfW-1:0] result_hi;
		logic [HalfW-1:0]        result_lo;
		logic                    status;
	} out_beat_t;

	// Classified job: magnitudes plus early decisions from the front end
	typedef struct packed {
		logic             lcm;
		logic             done;
		logic             err;
		logic [WordW-1:0] mag_a;
		logic [WordW-1:0] mag_b;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EUCLID,
		ST_DIV,
		ST_MUL,
		ST_OUT
	} state_t;

endpackage

FILE: rtl/core/sgl_front.sv
// ----------------------------------------------------------------------------
// sgl_front: input classification
// Takes an operand beat, forms magnitudes and settles the special cases
// (minimum value, zeros) before the job enters the queue.
// ----------------------------------------------------------------------------
module sgl_front (
	input  sgl_pkg::in_beat_t beat,
	output sgl_pkg::job_t     job
);
	import sgl_pkg::*;

	logic [WordW-1:0] a, b;
	logic a_min, b_min, a_zero, b_zero, gerr;

	assign a = {beat.a_hi, beat.a_lo};
	assign b = {beat.b_hi, beat.b_lo};

	// Special-case detection
	assign a_min  = (a == {1'b1, {(WordW-1){1'b0}}});
	assign b_min  = (b == {1'b1, {(WordW-1){1'b0}}});
	assign a_zero = (a == '0);
	assign b_zero = (b == '0);
	assign gerr   = (a_min && (b_zero || b_min)) || (b_min && a_zero);

	always_comb begin
		job.lcm   = (beat.mode == MODE_LCM);
		job.mag_a = a[WordW-1] ? (~a + 1'b1) : a;
		job.mag_b = b[WordW-1] ? (~b + 1'b1) : b;
		job.done  = 1'b0;
		job.err   = 1'b0;
		if (beat.mode == MODE_LCM && (a_zero || b_zero)) begin
			job.done = 1'b1;
		end else if (gerr) begin
			job.done = 1'b1;
			job.err  = 1'b1;
		end
	end

endmodule

FILE: rtl/core/sgl_queue.sv
// ----------------------------------------------------------------------------
// sgl_queue: small job queue between front and back
// Register-based FIFO; decouples input acceptance from the arithmetic.
// ----------------------------------------------------------------------------
module sgl_queue #(
	parameter int unsigned Depth = sgl_pkg::QueueDepthDef
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  sgl_pkg::job_t wdata,
	output logic          full,
	input  logic          rd,
	output sgl_pkg::job_t rdata,
	output logic          empty
);
	import sgl_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

	job_t            mem_q [Depth];
	logic [PtrW-1:0] wp_q, rp_q;
	logic [PtrW:0]   cnt_q;

	assign full  = (cnt_q == (PtrW+1)'(Depth));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	// Storage
	always_ff @(posedge clk) begin
		if (wr && !full) begin
			mem_q[wp_q] <= wdata;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr && !full) begin
				wp_q <= (wp_q == PtrW'(Depth-1)) ? '0 : wp_q + 1'b1;
			end
			if (rd && !empty) begin
				rp_q <= (rp_q == PtrW'(Depth-1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (PtrW+1)'(wr && !full) - (PtrW+1)'(rd && !empty);
		end
	end

endmodule

FILE: rtl/core/sgl_back.sv
// ----------------------------------------------------------------------------
// sgl_back: gcd/lcm sequencer
// Euclid by repeated restoring division (one quotient bit per cycle),
// then for lcm one more division |a|/g and a 32x32-digit serial multiply.
// ----------------------------------------------------------------------------
module sgl_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	input  sgl_pkg::job_t      job,
	output logic               job_take,
	output logic               res_valid,
	output sgl_pkg::out_beat_t res,
	input  logic               res_take
);
	import sgl_pkg::*;

	state_t state_q, state_d;

	logic [WordW-1:0] x_q, y_q, ma_q, mb_q, n_q, rem_q, quo_q;
	logic [CntW-1:0]  bit_q;
	logic             lcm_q, err_q;
	logic [1:0]       mi_q, mj_q;
	logic [255:0]     acc_q;
	logic [WordW-1:0] res_val_q;

	// One restoring step
	logic [WordW:0]   shr;
	logic [WordW:0]   diff;
	logic             take_bit;
	logic [WordW-1:0] rem_nx, quo_nx;
	logic [WordW-1:0] divisor;

	assign divisor  = (state_q == ST_DIV) ? x_q : y_q;
	assign shr      = {rem_q, n_q[WordW-1]};
	assign diff     = shr - {1'b0, divisor};
	assign take_bit = !diff[WordW];
	assign rem_nx   = take_bit ? diff[WordW-1:0] : shr[WordW-1:0];
	assign quo_nx   = {quo_q[WordW-2:0], take_bit};

	// Multiply digit
	logic [31:0] xd, yd;
	logic [63:0] pp;
	assign xd = quo_q[mi_q*32 +: 32];
	assign yd = mb_q[mj_q*32 +: 32];
	assign pp = xd * yd;

	// Digit weight reaches 192, so the shift amount needs 8 bits
	logic [255:0] acc_nx;
	assign acc_nx = acc_q + ({192'd0, pp} << ({1'b0, mi_q, 5'd0} + {1'b0, mj_q, 5'd0}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		job_take = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					job_take = 1'b1;
					if (job.done) state_d = ST_OUT;
					else if (job.mag_b == '0) state_d = job.lcm ? ST_DIV : ST_OUT;
					else state_d = ST_EUCLID;
				end
			end
			ST_EUCLID: begin
				if (bit_q == '0 && rem_nx == '0) state_d = lcm_q ? ST_DIV : ST_OUT;
			end
			ST_DIV: begin
				if (bit_q == '0) state_d = ST_MUL;
			end
			ST_MUL: begin
				if (mi_q == 2'd3 && mj_q == 2'd3) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (res_take) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				lcm_q     <= job.lcm;
				err_q     <= job.err;
				ma_q      <= job.mag_a;
				mb_q      <= job.mag_b;
				x_q       <= job.mag_a;
				y_q       <= job.mag_b;
				res_val_q <= job.done ? '0 : job.mag_a;
				rem_q     <= '0;
				quo_q     <= '0;
				n_q       <= job.mag_a;
				bit_q     <= '1;
				if (!job.done && job.mag_b == '0) begin
					n_q <= job.mag_a;
				end
			end
			ST_EUCLID: begin
				rem_q <= rem_nx;
				n_q   <= {n_q[WordW-2:0], 1'b0};
				bit_q <= bit_q - 1'b1;
				if (bit_q == '0) begin
					x_q   <= y_q;
					y_q   <= rem_nx;
					rem_q <= '0;
					n_q   <= y_q;
					res_val_q <= y_q;
					if (rem_nx == '0) begin
						n_q <= ma_q;
						quo_q <= '0;
						x_q <= y_q;
					end
				end
			end
			ST_DIV: begin
				rem_q <= rem_nx;
				quo_q <= quo_nx;
				n_q   <= {n_q[WordW-2:0], 1'b0};
				bit_q <= bit_q - 1'b1;
				acc_q <= '0;
				mi_q  <= '0;
				mj_q  <= '0;
			end
			ST_MUL: begin
				acc_q <= acc_nx;
				mj_q  <= mj_q + 1'b1;
				if (mj_q == 2'd3) mi_q <= mi_q + 1'b1;
				if (mi_q == 2'd3 && mj_q == 2'd3) begin
					err_q     <= (acc_nx[255:127] != '0);
					res_val_q <= (acc_nx[255:127] != '0) ? '0 : acc_nx[127:0];
				end
			end
			default: ;
		endcase
	end

	assign res_valid     = (state_q == ST_OUT);
	assign res.result_hi = res_val_q[WordW-1:HalfW];
	assign res.result_lo = res_val_q[HalfW-1:0];
	assign res.status    = err_q;

endmodule

FILE: rtl/core/signed128_gcd_lcm.sv
// ----------------------------------------------------------------------------
// signed128_gcd_lcm: signed 128-bit gcd / lcm unit
// Sequence: Euclid division steps (up to about 186 steps), then for lcm the
// quotient |a|/g and the digit multiply; special cases settled in the front
// end skip the arithmetic and go straight to the output state.
// Throughput: one item at a time in the back end, set by the single
// shift-subtract divider; a held result blocks it, the queue takes two more.
// Reset: arst_n clears queue pointers and the sequencer; payload is not reset.
// ----------------------------------------------------------------------------
module signed128_gcd_lcm #(
	parameter int unsigned QueueDepth = sgl_pkg::QueueDepthDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  sgl_pkg::in_beat_t   in_beat,
	output logic                empty,
	input  logic                pop,
	output sgl_pkg::out_beat_t  out_beat
);
	import sgl_pkg::*;

	job_t f_job, q_job;
	logic q_empty, q_take, r_valid;

	sgl_front u_front (.beat(in_beat), .job(f_job));

	sgl_queue #(.Depth(QueueDepth)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr(push), .wdata(f_job), .full(full),
		.rd(q_take), .rdata(q_job), .empty(q_empty)
	);

	sgl_back u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(!q_empty), .job(q_job), .job_take(q_take),
		.res_valid(r_valid), .res(out_beat), .res_take(pop)
	);

	assign empty = !r_valid;

endmodule
